// ----- design/lpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpsd_pkg: shared types, constants and functions
// Field widths, register indexes, duty thresholds and the LED pattern table
// of the LED pattern sequencer with PWM dimming.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

    localparam int PWM_PERIOD_DEF    = 100;
    localparam int PATTERN_STEPS_DEF = 8;

    localparam int SAMPLE_W  = 8;
    localparam int LED_W     = 8;
    localparam int STEP_W    = 3;
    localparam int PHASE_W   = 7;
    localparam int TIMER_W   = 16;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    // Ambient thresholds (strictly above) and the duty they select.
    localparam logic [SAMPLE_W-1:0] LIGHT_TH_HI  = 8'd192;
    localparam logic [SAMPLE_W-1:0] LIGHT_TH_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] LIGHT_TH_LO  = 8'd64;
    localparam logic [PHASE_W-1:0]  DUTY_HI      = 7'd90;
    localparam logic [PHASE_W-1:0]  DUTY_MID     = 7'd60;
    localparam logic [PHASE_W-1:0]  DUTY_LO      = 7'd30;
    localparam logic [PHASE_W-1:0]  DUTY_MIN     = 7'd10;

    localparam logic [MODE_W-1:0]  MODE_RST   = 3'd1;
    localparam logic [TIMER_W-1:0] PERIOD_RST = 16'd4000;
    localparam logic               RUN_RST    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 2'd0,
        REG_STEP_PERIOD  = 2'd1,
        REG_RUN_ENABLE   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TIMER_W-1:0] period;
        logic               run;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic [STEP_W-1:0]  index;
        logic [PHASE_W-1:0] phase;
        logic [LED_W-1:0]   hold;
    } seq_state_t;

    function automatic logic [PHASE_W-1:0] duty_of(input logic [SAMPLE_W-1:0] sample);
        logic [PHASE_W-1:0] d;
        if (sample > LIGHT_TH_HI) begin
            d = DUTY_HI;
        end else if (sample > LIGHT_TH_MID) begin
            d = DUTY_MID;
        end else if (sample > LIGHT_TH_LO) begin
            d = DUTY_LO;
        end else begin
            d = DUTY_MIN;
        end
        return d;
    endfunction

    // Mode 1 walks up, 2 walks down, 3 outside-in pairs, 4 inside-out pairs.
    // Out-of-range modes fold onto row (mode-1) mod 4.
    function automatic logic [LED_W-1:0] pattern_row(input logic [MODE_W-1:0] mode,
                                                     input logic [STEP_W-1:0] idx);
        logic [1:0]       row;
        logic [LED_W-1:0] pat;
        row = 2'(mode + 3'd3);
        case (row)
            2'd0: pat = 8'h01 << idx;
            2'd1: pat = 8'h80 >> idx;
            2'd2: begin
                case (idx[1:0])
                    2'd0:    pat = 8'h81;
                    2'd1:    pat = 8'h42;
                    2'd2:    pat = 8'h24;
                    default: pat = 8'h18;
                endcase
            end
            default: begin
                case (idx[1:0])
                    2'd0:    pat = 8'h18;
                    2'd1:    pat = 8'h24;
                    2'd2:    pat = 8'h42;
                    default: pat = 8'h81;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- design/lpsd_tick_logic.sv -----
// ----------------------------------------------------------------------------
// lpsd_tick_logic: next-state and LED logic for one tick
// Step timer, step index, PWM phase and LED gating, all in one short pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_tick_logic
    import lpsd_pkg::*;
#(
    parameter int PWM_PERIOD    = PWM_PERIOD_DEF,
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
    input  cfg_t                cfg,
    input  seq_state_t          cur,
    input  logic [SAMPLE_W-1:0] sample,
    output seq_state_t          nxt,
    output logic [LED_W-1:0]    led_lit
);

    localparam logic [STEP_W:0]  STEPS_LIM = (STEP_W+1)'(PATTERN_STEPS);
    localparam logic [PHASE_W:0] PHASE_LIM = (PHASE_W+1)'(PWM_PERIOD);

    logic [TIMER_W-1:0] timer_inc;
    logic               step_hit;
    logic [STEP_W:0]    idx_inc;
    logic [STEP_W-1:0]  idx_new;
    logic [PHASE_W:0]   phase_inc;
    logic               phase_wrap;
    logic [PHASE_W-1:0] duty;

    always_comb begin
        // timer saturates so a frozen sequencer steps right after resuming
        timer_inc = (cur.timer != '1) ? cur.timer + 1'b1 : cur.timer;
        step_hit  = (timer_inc >= cfg.period) && cfg.run;
        idx_inc   = {1'b0, cur.index} + 1'b1;
        if (step_hit) begin
            idx_new = (idx_inc >= STEPS_LIM) ? '0 : idx_inc[STEP_W-1:0];
        end else begin
            idx_new = cur.index;
        end

        phase_inc  = {1'b0, cur.phase} + 1'b1;
        phase_wrap = (phase_inc >= PHASE_LIM);
        duty       = duty_of(sample);

        if (phase_wrap) begin
            led_lit = cur.hold;
        end else if (phase_inc >= {1'b0, duty}) begin
            led_lit = '0;
        end else begin
            led_lit = pattern_row(cfg.mode, idx_new);
        end

        nxt.timer = step_hit ? '0 : timer_inc;
        nxt.index = idx_new;
        nxt.phase = phase_wrap ? '0 : phase_inc[PHASE_W-1:0];
        nxt.hold  = led_lit;
    end

endmodule

`default_nettype wire

// ----- design/led_pattern_sequencer_pwm_dim_unit.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer_pwm_dim_unit: LED pattern sequencer with PWM dimming
// One input beat per tick carries an ambient light sample; one output beat
// per tick carries the eight LED states and the current pattern step.
// ----------------------------------------------------------------------------
// Each input beat is one tick. The block takes a beat every clock cycle while
// the output side is not stalled and returns exactly one result beat per
// input beat, held first in the input register, then in the result register.
// All counter updates for a tick (step timer, step index, PWM phase, held
// LED state) happen in the cycle the tick moves from the input register to
// the result register, so ticks can follow back to back.
// Back pressure on m_ stalls only the stages behind a full result register.
// Configuration writes (pattern_mode, step_period, run_enable at indexes
// 0, 1, 2) take effect at once and are meant to be issued while idle; a
// write to index 3 is ignored.
`default_nettype none

module led_pattern_sequencer_pwm_dim_unit
    import lpsd_pkg::*;
#(
    parameter int PWM_PERIOD    = PWM_PERIOD_DEF,
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // config write port
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // [7:0] light_sample

    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata    // [7:0] led_lit, [10:8] step_now, rest 0
);

    cfg_t                cfg_reg;
    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [LED_W-1:0]    lit_next;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                advance;   // input register beat moves to result register
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= MODE_RST;
            cfg_reg.period <= PERIOD_RST;
            cfg_reg.run    <= RUN_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_PATTERN_MODE: cfg_reg.mode   <= cfg_wdata[MODE_W-1:0];
                REG_STEP_PERIOD:  cfg_reg.period <= cfg_wdata[TIMER_W-1:0];
                REG_RUN_ENABLE:   cfg_reg.run    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lpsd_tick_logic #(
        .PWM_PERIOD    (PWM_PERIOD),
        .PATTERN_STEPS (PATTERN_STEPS)
    ) u_tick (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .sample  (in_sample_reg),
        .nxt     (state_next),
        .led_lit (lit_next)
    );

    // sequencer state, all cleared by reset (LEDs dark)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {(M_DATA_W-STEP_W-LED_W)'(0), state_next.index, lit_next};
        end
    end

endmodule

`default_nettype wire

// ----- design/lpsd_checker.sv -----
// ----------------------------------------------------------------------------
// lpsd_checker: port-level checks of the LED pattern sequencer
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_checker
    import lpsd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input only backs up behind a waiting result beat
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back pressure");

    // every pattern row lights one or two LEDs, dark phases none
    a_led_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[LED_W-1:0]) <= 2)
        else $error("more than two LEDs lit");

    // padding bits above step_now stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:LED_W+STEP_W] == '0)
        else $error("nonzero padding in result beat");

    // no result beat right after reset without an input beat
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat out of reset");

endmodule

bind led_pattern_sequencer_pwm_dim_unit lpsd_checker u_lpsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
